### hdl/mrds_pkg.sv
// Shared types, constants and the CRC bit step for the Modbus RTU drive slave.
package mrds_pkg;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [15:0] COIL_ON        = 16'hFF00;
  localparam logic [7:0]  EXC_FLAG       = 8'h80;
  localparam logic [7:0]  FREQ_DIVISOR   = 8'd100;
  localparam int          MAX_READ_WORDS = 29;

  localparam logic [7:0] FN_READ_INPUT  = 8'd4;
  localparam logic [7:0] FN_WRITE_COIL  = 8'd5;
  localparam logic [7:0] FN_WRITE_REG   = 8'd6;
  localparam logic [7:0] EXC_BAD_FUNC   = 8'd1;
  localparam logic [7:0] EXC_BAD_VALUE  = 8'd3;

  localparam logic [15:0] RUN_COIL      = 16'd0;
  localparam logic [15:0] FREQ_REG      = 16'd1;
  localparam logic [16:0] CURRENT_REG   = 17'd2;
  localparam logic [16:0] VOLTAGE_REG   = 17'd3;

  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_CURRENT    = 2'd1;
  localparam logic [1:0] CFG_VOLTAGE    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_LOAD,
    ST_BCRC,
    ST_OUT
  } state_t;

  // One bit of the reflected CRC-16, data bit fed LSB first.
  function automatic logic [15:0] crc_bit(input logic [15:0] crc, input logic b);
    logic fb;
    fb = crc[0] ^ b;
    return (crc >> 1) ^ (fb ? CRC_POLY : 16'h0000);
  endfunction

endpackage

### hdl/modbus_rtu_drive_slave_top.sv
// Modbus RTU drive slave: frame window, bit-serial CRC check and response builder.
//
// Bytes enter on the rx channel into an eight-byte sliding window. Once eight
// bytes are held, the first six are run through a bit-serial CRC-16 (one bit a
// cycle) and the frame is checked against the station address and its
// little-endian CRC trailer; a bad window drops its oldest byte. A good
// frame is answered on the tx channel, one byte per request, each payload byte
// first shifted through the same CRC register, the two CRC bytes last with
// last_of_frame set on the final one. Function 6 at register 1 sets the
// frequency to value/100 through a serial divider. rx_ready is high only
// while no frame is being checked or answered: a byte that does not complete
// a window leaves it high, a rejected window holds it low for the check, and
// an accepted frame for the check, the divider on a frequency write, a load,
// CRC shift and output step per payload byte and a load and output step per
// CRC byte, plus tx stalls. Read requests above MAX_WORDS words get an
// exception. run_flag and frequency_hz always show the current drive state.
module modbus_rtu_drive_slave_top
  import mrds_pkg::*;
#(
  parameter int MAX_WORDS = MAX_READ_WORDS
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        tx_valid,
  input  logic        tx_ready,
  output logic [7:0]  tx_byte,
  output logic        last_of_frame,
  output logic        run_flag,
  output logic [9:0]  frequency_hz,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  state_t state, state_next;

  logic [7:0]  win [8];
  logic [2:0]  fill;
  logic        running;
  logic [9:0]  set_frequency;
  logic [7:0]  slave_address;
  logic [15:0] current_reading;
  logic [15:0] voltage_reading;

  logic [15:0] crc;
  logic [47:0] sreg;      // serial CRC feed
  logic [5:0]  cnt;
  logic [5:0]  k;         // response byte index
  logic [15:0] divq;      // dividend in, quotient out
  logic [6:0]  rem;
  logic [7:0]  tx_reg;
  logic        last_reg;

  // frame fields
  logic [7:0]  func;
  logic [15:0] addr, value;
  assign func  = win[1];
  assign addr  = {win[2], win[3]};
  assign value = {win[4], win[5]};

  logic frame_ok;
  assign frame_ok = (win[0] == slave_address) && (crc == {win[7], win[6]});

  // response payload length before CRC
  logic        is_echo, is_read, read_exc;
  logic [5:0]  len;
  assign is_echo  = (func == FN_WRITE_COIL) || (func == FN_WRITE_REG);
  assign is_read  = (func == FN_READ_INPUT);
  assign read_exc = value > 16'(MAX_WORDS);
  always_comb begin
    if (is_echo) len = 6'd6;
    else if (is_read && !read_exc) len = 6'd3 + {value[4:0], 1'b0};
    else len = 6'd3;
  end

  // byte k of the response payload
  logic [5:0]  widx;
  logic [16:0] reg_no;
  logic [15:0] word;
  logic [7:0]  resp_byte;
  assign widx   = (k - 6'd3) >> 1;
  assign reg_no = {1'b0, addr} + {11'd0, widx};
  always_comb begin
    if (reg_no == CURRENT_REG) word = current_reading;
    else if (reg_no == VOLTAGE_REG) word = voltage_reading;
    else word = 16'd0;
  end
  always_comb begin
    if (is_echo) begin
      resp_byte = win[k[2:0]];
    end else if (k == 6'd0) begin
      resp_byte = slave_address;
    end else if (k == 6'd1) begin
      resp_byte = (is_read && !read_exc) ? FN_READ_INPUT : (func | EXC_FLAG);
    end else if (k == 6'd2) begin
      if (!is_read) resp_byte = EXC_BAD_FUNC;
      else if (read_exc) resp_byte = EXC_BAD_VALUE;
      else resp_byte = {value[6:0], 1'b0};
    end else begin
      // data words go out high byte first
      resp_byte = k[0] ? word[15:8] : word[7:0];
    end
  end

  logic [7:0] div_try;
  assign div_try = {rem, divq[15]};

  assign rx_ready      = (state == ST_IDLE);
  assign tx_valid      = (state == ST_OUT);
  assign tx_byte       = tx_reg;
  assign last_of_frame = last_reg;
  assign run_flag      = running;
  assign frequency_hz  = set_frequency;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (rx_valid && fill == 3'd7) state_next = ST_CHECK;
      ST_CHECK: begin
        if (cnt == 6'd48) begin
          if (!frame_ok) state_next = ST_IDLE;
          else if (func == FN_WRITE_REG && addr == FREQ_REG) state_next = ST_DIV;
          else state_next = ST_LOAD;
        end
      end
      ST_DIV:   if (cnt == 6'd15) state_next = ST_LOAD;
      ST_LOAD:  state_next = (k < len) ? ST_BCRC : ST_OUT;
      ST_BCRC:  if (cnt == 6'd7) state_next = ST_OUT;
      ST_OUT:   if (tx_ready) state_next = last_reg ? ST_IDLE : ST_LOAD;
      default:  state_next = ST_IDLE;
    endcase
  end

  // config and drive state
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address   <= 8'd1;
      current_reading <= 16'd0;
      voltage_reading <= 16'd0;
      running         <= 1'b0;
      set_frequency   <= 10'd0;
      fill            <= 3'd0;
      for (int i = 0; i < 8; i++) win[i] <= 8'd0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_SLAVE_ADDR: slave_address   <= cfg_data[7:0];
          CFG_CURRENT:    current_reading <= cfg_data;
          CFG_VOLTAGE:    voltage_reading <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (rx_valid) begin
            win[fill] <= rx_byte;
            if (fill != 3'd7) fill <= fill + 3'd1;
          end
        end
        ST_CHECK: begin
          if (cnt == 6'd48) begin
            if (!frame_ok) begin
              for (int i = 0; i < 7; i++) win[i] <= win[i+1];
            end else begin
              fill <= 3'd0;
              if (func == FN_WRITE_COIL && addr == RUN_COIL) running <= (value == COIL_ON);
            end
          end
        end
        ST_DIV: if (cnt == 6'd15) set_frequency <= {divq[8:0], (div_try >= FREQ_DIVISOR)};
        default: ;
      endcase
    end
  end

  // datapath: CRC shifter, divider, response index, output register
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cnt  <= 6'd0;
        crc  <= CRC_INIT;
        sreg <= {win[5], win[4], win[3], win[2], win[1], win[0]};
        k    <= 6'd0;
        last_reg <= 1'b0;
      end
      ST_CHECK: begin
        if (cnt == 6'd48) begin
          crc  <= CRC_INIT;
          cnt  <= 6'd0;
          divq <= value;
          rem  <= 7'd0;
        end else begin
          crc  <= crc_bit(crc, sreg[0]);
          sreg <= sreg >> 1;
          cnt  <= cnt + 6'd1;
        end
      end
      ST_DIV: begin
        if (div_try >= FREQ_DIVISOR) rem <= 7'(div_try - FREQ_DIVISOR);
        else rem <= div_try[6:0];
        divq <= {divq[14:0], (div_try >= FREQ_DIVISOR)};
        cnt  <= cnt + 6'd1;
      end
      ST_LOAD: begin
        cnt <= 6'd0;
        if (k < len) begin
          tx_reg     <= resp_byte;
          sreg[7:0]  <= resp_byte;
        end else if (k == len) begin
          tx_reg <= crc[7:0];
        end else begin
          tx_reg   <= crc[15:8];
          last_reg <= 1'b1;
        end
      end
      ST_BCRC: begin
        crc       <= crc_bit(crc, sreg[0]);
        sreg[7:0] <= sreg[7:0] >> 1;
        cnt       <= cnt + 6'd1;
      end
      ST_OUT: if (tx_ready) k <= k + 6'd1;
      default: ;
    endcase
  end

endmodule
